[hw/rtl/ofsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofsm_pkg
// types, codes and constants shared by the neighbor state machine modules
// ----------------------------------------------------------------------------
package ofsm_pkg;

  typedef enum logic [3:0] {
    ST_NONE     = 4'd0,
    ST_DOWN     = 4'd1,
    ST_ATTEMPT  = 4'd2,
    ST_INIT     = 4'd3,
    ST_TWOWAY   = 4'd4,
    ST_EXSTART  = 4'd5,
    ST_EXCHANGE = 4'd6,
    ST_LOADING  = 4'd7,
    ST_FULL     = 4'd8
  } nbr_state_e;

  typedef enum logic [3:0] {
    OP_TICK         = 4'd0,
    OP_HELLO        = 4'd1,
    OP_TWOWAY       = 4'd2,
    OP_NEG_DONE     = 4'd3,
    OP_EXCH_DONE    = 4'd4,
    OP_LOAD_DONE    = 4'd5,
    OP_ADJ_OK       = 4'd6,
    OP_SEQ_MISMATCH = 4'd7,
    OP_BAD_LSREQ    = 4'd8,
    OP_ONEWAY       = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ROLE_OTHER = 2'd0,
    ROLE_P2P   = 2'd1,
    ROLE_DR    = 2'd2,
    ROLE_BDR   = 2'd3
  } role_e;

  typedef enum logic {
    CFG_NEIGHBOR_ID = 1'b0,
    CFG_DEAD_TICKS  = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CountW   = 16;
  localparam logic [CountW-1:0] DeadTicksReset = CountW'(40);

  localparam int unsigned FlagMaster = 0;
  localparam int unsigned FlagMore   = 1;
  localparam int unsigned FlagInit   = 2;
  localparam logic [2:0]  FlagsAll   = 3'b111;

  typedef struct packed {
    logic [3:0]  operation;
    logic [1:0]  interface_role;
    logic [31:0] designated_router;
    logic [31:0] backup_router;
    logic        requests_empty;
  } in_t;

  typedef struct packed {
    logic [3:0] neighbor_state;
    logic       state_changed;
    logic       schedule_router_lsa;
    logic       schedule_prefix_lsa;
    logic       nbr_change_evt;
    logic       send_dbdesc;
    logic       flush_lists;
    logic       load_summary;
    logic       flag_master;
    logic       flag_more;
    logic       flag_init;
    logic       neighbor_down;
  } out_t;

  typedef struct packed {
    logic [31:0]       neighbor_id;
    logic [CountW-1:0] dead_ticks;
  } cfg_t;

  typedef struct packed {
    nbr_state_e        state;
    logic [2:0]        flags;
    logic [CountW-1:0] idle_count;
    logic              timer_running;
  } nbr_ctx_t;

endpackage

[hw/rtl/ofsm_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofsm_cfg
// configuration registers: neighbor router id and dead interval
// ----------------------------------------------------------------------------
module ofsm_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [ofsm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output ofsm_pkg::cfg_t                   cfg_o
);

  ofsm_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neighbor_id <= '0;
      cfg_q.dead_ticks  <= ofsm_pkg::DeadTicksReset;
    end else if (cfg_we_i) begin
      case (ofsm_pkg::cfg_idx_e'(cfg_idx_i))
        ofsm_pkg::CFG_NEIGHBOR_ID: cfg_q.neighbor_id <= cfg_wdata_i[31:0];
        ofsm_pkg::CFG_DEAD_TICKS:  cfg_q.dead_ticks  <= cfg_wdata_i[ofsm_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/ofsm_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofsm_step
// next-state and result logic for one event or tick
// ----------------------------------------------------------------------------
module ofsm_step (
  input  ofsm_pkg::in_t     in_i,
  input  ofsm_pkg::cfg_t    cfg_i,
  input  ofsm_pkg::nbr_ctx_t ctx_i,
  output ofsm_pkg::nbr_ctx_t ctx_o,
  output ofsm_pkg::out_t    res_o
);

  logic adj_needed;
  logic nbr_change, send_dd, flush, load, down;
  logic changed, router_lsa;

  assign adj_needed = (ofsm_pkg::role_e'(in_i.interface_role) != ofsm_pkg::ROLE_OTHER)
                   || (in_i.designated_router == cfg_i.neighbor_id)
                   || (in_i.backup_router == cfg_i.neighbor_id);

  always_comb begin
    ctx_o      = ctx_i;
    nbr_change = 1'b0;
    send_dd    = 1'b0;
    flush      = 1'b0;
    load       = 1'b0;
    down       = 1'b0;
    case (ofsm_pkg::op_e'(in_i.operation))
      ofsm_pkg::OP_TICK: begin
        if (ctx_i.timer_running) begin
          if (ctx_i.idle_count <= ofsm_pkg::CountW'(1)) begin
            ctx_o.idle_count    = '0;
            ctx_o.timer_running = 1'b0;
            ctx_o.state         = ofsm_pkg::ST_DOWN;
            ctx_o.flags         = '0;
            nbr_change          = 1'b1;
            down                = 1'b1;
          end else begin
            ctx_o.idle_count = ctx_i.idle_count - ofsm_pkg::CountW'(1);
          end
        end
      end
      ofsm_pkg::OP_HELLO: begin
        ctx_o.idle_count    = cfg_i.dead_ticks;
        ctx_o.timer_running = 1'b1;
        if (ctx_i.state inside {ofsm_pkg::ST_NONE, ofsm_pkg::ST_DOWN}) begin
          ctx_o.state = ofsm_pkg::ST_INIT;
        end
      end
      ofsm_pkg::OP_TWOWAY: begin
        if (ctx_i.state <= ofsm_pkg::ST_INIT) begin
          nbr_change = 1'b1;
          if (!adj_needed) begin
            ctx_o.state = ofsm_pkg::ST_TWOWAY;
          end else begin
            ctx_o.state = ofsm_pkg::ST_EXSTART;
            ctx_o.flags = ofsm_pkg::FlagsAll;
            send_dd     = 1'b1;
          end
        end
      end
      ofsm_pkg::OP_NEG_DONE: begin
        if (ctx_i.state == ofsm_pkg::ST_EXSTART) begin
          flush                           = 1'b1;
          load                            = 1'b1;
          ctx_o.flags[ofsm_pkg::FlagInit] = 1'b0;
          ctx_o.state                     = ofsm_pkg::ST_EXCHANGE;
        end
      end
      ofsm_pkg::OP_EXCH_DONE: begin
        if (ctx_i.state == ofsm_pkg::ST_EXCHANGE) begin
          ctx_o.state = in_i.requests_empty ? ofsm_pkg::ST_FULL : ofsm_pkg::ST_LOADING;
        end
      end
      ofsm_pkg::OP_LOAD_DONE: begin
        if (ctx_i.state == ofsm_pkg::ST_LOADING) begin
          ctx_o.state = ofsm_pkg::ST_FULL;
        end
      end
      ofsm_pkg::OP_ADJ_OK: begin
        if ((ctx_i.state == ofsm_pkg::ST_TWOWAY) && adj_needed) begin
          ctx_o.state = ofsm_pkg::ST_EXSTART;
          ctx_o.flags = ofsm_pkg::FlagsAll;
          send_dd     = 1'b1;
        end
      end
      ofsm_pkg::OP_SEQ_MISMATCH, ofsm_pkg::OP_BAD_LSREQ: begin
        if (ctx_i.state >= ofsm_pkg::ST_EXCHANGE) begin
          ctx_o.state = ofsm_pkg::ST_EXSTART;
          ctx_o.flags = ofsm_pkg::FlagsAll;
          flush       = 1'b1;
          send_dd     = 1'b1;
        end
      end
      ofsm_pkg::OP_ONEWAY: begin
        if (ctx_i.state >= ofsm_pkg::ST_TWOWAY) begin
          ctx_o.state = ofsm_pkg::ST_INIT;
          nbr_change  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign changed    = (ctx_o.state != ctx_i.state);
  assign router_lsa = changed && ((ctx_i.state == ofsm_pkg::ST_FULL)
                               || (ctx_o.state == ofsm_pkg::ST_FULL));

  always_comb begin
    res_o.neighbor_state      = ctx_o.state;
    res_o.state_changed       = changed;
    res_o.schedule_router_lsa = router_lsa;
    res_o.schedule_prefix_lsa = router_lsa
        && (ofsm_pkg::role_e'(in_i.interface_role) == ofsm_pkg::ROLE_DR);
    res_o.nbr_change_evt      = nbr_change;
    res_o.send_dbdesc         = send_dd;
    res_o.flush_lists         = flush;
    res_o.load_summary        = load;
    res_o.flag_master         = ctx_o.flags[ofsm_pkg::FlagMaster];
    res_o.flag_more           = ctx_o.flags[ofsm_pkg::FlagMore];
    res_o.flag_init           = ctx_o.flags[ofsm_pkg::FlagInit];
    res_o.neighbor_down       = down;
  end

endmodule

[hw/rtl/ospf_neighbor_fsm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ospf_neighbor_fsm_core
// neighbor state machine for one neighbor, one result per event or tick
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid_i / in_stall_o carries one event or tick per
//   transaction in in_data_i; the output channel out_valid_o / out_stall_i
//   returns exactly one result per input, in order, in out_data_o
//   an input lands in the input register at acceptance; once the result
//   register is free, the state update runs and loads the result register
//   throughput is one transaction per cycle while out_stall_i is low, set
//   by the single state update between input register and result register
//   when the receiver stalls, the result holds; one more input can wait in
//   the input register, after which in_stall_o is raised
//   configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at the
//   next edge; the user must make them only while the block is idle, and
//   the block itself does not enforce this
//   reset leaves the neighbor in Down with flags cleared, the inactivity
//   timer stopped, neighbor id 0 and a dead interval of 40 ticks
// ----------------------------------------------------------------------------
module ospf_neighbor_fsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ofsm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ofsm_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ofsm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  ofsm_pkg::cfg_t     cfg;
  ofsm_pkg::in_t      in_q;
  logic               in_valid_q;
  ofsm_pkg::nbr_ctx_t ctx_q, ctx_d;
  ofsm_pkg::out_t     res_d, out_q;
  logic               out_valid_q;
  logic               out_free, advance, in_accept;

  ofsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ofsm_step u_step (
    .in_i  (in_q),
    .cfg_i (cfg),
    .ctx_i (ctx_q),
    .ctx_o (ctx_d),
    .res_o (res_d)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.state         <= ofsm_pkg::ST_DOWN;
      ctx_q.flags         <= '0;
      ctx_q.idle_count    <= '0;
      ctx_q.timer_running <= 1'b0;
    end else if (advance) begin
      ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
